### hw/rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the I2C master byte engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int NUM_BUSES = 3;
  localparam int DATA_BITS = 8;
  localparam int BUS_W     = 2;
  localparam int OP_W      = 3;
  localparam int TICK_W    = 16;
  localparam int STEP_W    = 5;
  localparam int SUB_W     = 2;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [TICK_W-1:0] TICK_RESET = TICK_W'(125);

  // Event index of the final event per command, and write landmarks
  localparam logic [STEP_W-1:0] START_LAST     = STEP_W'(3);
  localparam logic [STEP_W-1:0] STOP_LAST      = STEP_W'(2);
  localparam logic [STEP_W-1:0] WRITE_BITS_END = STEP_W'(3 * DATA_BITS);
  localparam logic [STEP_W-1:0] WRITE_ACK_STEP = STEP_W'(3 * DATA_BITS + 1);
  localparam logic [STEP_W-1:0] WRITE_LAST     = STEP_W'(3 * DATA_BITS + 2);
  localparam logic [STEP_W-1:0] READ_LAST      = STEP_W'(2 * DATA_BITS + 1);
  localparam logic [STEP_W-1:0] ACK_LAST       = STEP_W'(2);

  localparam logic [SUB_W-1:0] SUB_SDA  = SUB_W'(0);
  localparam logic [SUB_W-1:0] SUB_RISE = SUB_W'(1);
  localparam logic [SUB_W-1:0] SUB_FALL = SUB_W'(2);

  typedef enum logic [OP_W-1:0] {
    OP_START = 3'd0,
    OP_STOP  = 3'd1,
    OP_WRITE = 3'd2,
    OP_READ  = 3'd3,
    OP_ACK   = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_HOLD
  } back_state_e;

  // Classified command as queued between front and back
  typedef struct packed {
    opcode_e              op;
    logic [BUS_W-1:0]     bus;
    logic [DATA_BITS-1:0] wdata;
    logic                 mack;
    logic [DATA_BITS-1:0] sbyte;
    logic                 sack;
  } cmd_t;

endpackage

### hw/rtl/i2cm_if.sv
// ----------------------------------------------------------------------------
// i2cm_if
// Valid/ready channels: command requests, event results, configuration.
// ----------------------------------------------------------------------------
interface i2cm_cmd_if;
  import i2cm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      opcode;
  logic [BUS_W-1:0]     bus;
  logic [DATA_BITS-1:0] write_data;
  logic                 master_ack_level;
  logic [DATA_BITS-1:0] slave_byte;
  logic                 slave_ack_level;

  modport source (
    output valid, opcode, bus, write_data, master_ack_level, slave_byte, slave_ack_level,
    input  ready
  );
  modport sink (
    input  valid, opcode, bus, write_data, master_ack_level, slave_byte, slave_ack_level,
    output ready
  );
endinterface

interface i2cm_evt_if;
  import i2cm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 scl_level;
  logic                 sda_level;
  logic [BUS_W-1:0]     bus_out;
  logic [DATA_BITS-1:0] read_data;
  logic                 ack_received;
  logic                 last;

  modport source (
    output valid, scl_level, sda_level, bus_out, read_data, ack_received, last,
    input  ready
  );
  modport sink (
    input  valid, scl_level, sda_level, bus_out, read_data, ack_received, last,
    output ready
  );
endinterface

interface i2cm_cfg_if;
  import i2cm_pkg::*;

  logic              valid;
  logic              ready;
  logic [TICK_W-1:0] phase_ticks;

  modport source (output valid, phase_ticks, input ready);
  modport sink   (input valid, phase_ticks, output ready);
endinterface

### hw/rtl/i2cm_front.sv
// ----------------------------------------------------------------------------
// i2cm_front
// Accepts command requests, drops unknown opcodes, maps an out-of-range bus to 0.
// ----------------------------------------------------------------------------
module i2cm_front (
  i2cm_cmd_if.sink         cmd_i,
  input  logic             q_full_i,
  output logic             push_o,
  output i2cm_pkg::cmd_t   push_data_o
);
  import i2cm_pkg::*;

  logic known_op;

  assign cmd_i.ready = !q_full_i;

  always_comb begin
    known_op = cmd_i.opcode inside {OP_START, OP_STOP, OP_WRITE, OP_READ, OP_ACK};
  end

  // unknown opcodes are consumed without producing work
  assign push_o = cmd_i.valid && !q_full_i && known_op;

  always_comb begin
    push_data_o.op    = opcode_e'(cmd_i.opcode);
    push_data_o.bus   = (cmd_i.bus >= BUS_W'(NUM_BUSES)) ? '0 : cmd_i.bus;
    push_data_o.wdata = cmd_i.write_data;
    push_data_o.mack  = cmd_i.master_ack_level;
    push_data_o.sbyte = cmd_i.slave_byte;
    push_data_o.sack  = cmd_i.slave_ack_level;
  end

endmodule

### hw/rtl/i2cm_cmd_queue.sv
// ----------------------------------------------------------------------------
// i2cm_cmd_queue
// Short command FIFO between front and back.
// ----------------------------------------------------------------------------
module i2cm_cmd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  i2cm_pkg::cmd_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output i2cm_pkg::cmd_t pop_data_o,
  output logic           valid_o
);
  import i2cm_pkg::*;

  cmd_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] count_q, count_d;
  logic                  do_push, do_pop;

  assign full_o     = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### hw/rtl/i2cm_back.sv
// ----------------------------------------------------------------------------
// i2cm_back
// Event sequencer: pin state per bus, hold timer, registered event output.
// ----------------------------------------------------------------------------
module i2cm_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [i2cm_pkg::TICK_W-1:0]   phase_ticks_i,
  input  logic                          q_valid_i,
  input  i2cm_pkg::cmd_t                q_data_i,
  output logic                          q_pop_o,
  i2cm_evt_if.source                    evt_o
);
  import i2cm_pkg::*;

  back_state_e          state_q, state_d;
  cmd_t                 cmd_q, cmd_d;
  logic [STEP_W-1:0]    step_q, step_d;
  logic [SUB_W-1:0]     sub_q, sub_d;
  logic [DATA_BITS-1:0] wshift_q, wshift_d;
  logic [TICK_W-1:0]    hold_q, hold_d;
  logic                 was_last_q, was_last_d;
  logic                 ack_q, ack_d;
  logic [NUM_BUSES-1:0] scl_q, scl_d;
  logic [NUM_BUSES-1:0] sda_q, sda_d;

  logic                 out_valid_q, out_valid_d;
  logic                 out_scl_q, out_sda_q, out_ack_q, out_last_q;
  logic [BUS_W-1:0]     out_bus_q;
  logic [DATA_BITS-1:0] out_rdata_q;

  logic                 ev_is_scl, ev_level, ev_last;
  logic                 ev_scl, ev_sda;
  logic                 emit;

  // what the current step does to the pins
  always_comb begin
    ev_is_scl = 1'b0;
    ev_level  = 1'b1;
    ev_last   = 1'b0;
    case (cmd_q.op)
      OP_START: begin
        ev_is_scl = step_q[0];
        ev_level  = (step_q < STEP_W'(2));
        ev_last   = (step_q == START_LAST);
      end
      OP_STOP: begin
        ev_is_scl = step_q[0];
        ev_level  = (step_q != '0);
        ev_last   = (step_q == STOP_LAST);
      end
      OP_WRITE: begin
        case (sub_q)
          SUB_SDA: begin
            ev_is_scl = 1'b0;
            ev_level  = (step_q < WRITE_BITS_END) ? wshift_q[DATA_BITS-1] : 1'b1;
          end
          SUB_RISE: begin
            ev_is_scl = 1'b1;
            ev_level  = 1'b1;
          end
          default: begin
            ev_is_scl = 1'b1;
            ev_level  = 1'b0;
          end
        endcase
        ev_last = (step_q == WRITE_LAST);
      end
      OP_READ: begin
        ev_is_scl = (step_q != '0);
        ev_level  = (step_q == '0) ? 1'b1 : !step_q[0];
        ev_last   = (step_q == READ_LAST);
      end
      OP_ACK: begin
        ev_is_scl = (step_q != '0);
        ev_level  = (step_q == '0) ? cmd_q.mack : (step_q == STEP_W'(1));
        ev_last   = (step_q == ACK_LAST);
      end
      default: begin
        ev_last = 1'b1;
      end
    endcase
    ev_scl = ev_is_scl ? ev_level : scl_q[cmd_q.bus];
    ev_sda = ev_is_scl ? sda_q[cmd_q.bus] : ev_level;
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    step_d      = step_q;
    sub_d       = sub_q;
    wshift_d    = wshift_q;
    hold_d      = hold_q;
    was_last_d  = was_last_q;
    ack_d       = ack_q;
    scl_d       = scl_q;
    sda_d       = sda_q;
    q_pop_o     = 1'b0;
    emit        = 1'b0;
    out_valid_d = (out_valid_q && !evt_o.ready) ? 1'b1 : 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o  = 1'b1;
          cmd_d    = q_data_i;
          step_d   = '0;
          sub_d    = SUB_SDA;
          wshift_d = q_data_i.wdata;
          state_d  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || evt_o.ready) begin
          emit               = 1'b1;
          out_valid_d        = 1'b1;
          scl_d[cmd_q.bus]   = ev_scl;
          sda_d[cmd_q.bus]   = ev_sda;
          step_d             = step_q + 1'b1;
          sub_d              = (sub_q == SUB_FALL) ? SUB_SDA : sub_q + 1'b1;
          if (cmd_q.op == OP_WRITE && sub_q == SUB_FALL) begin
            wshift_d = {wshift_q[DATA_BITS-2:0], 1'b0};
          end
          // ack slot sampled while SCL is high
          if (cmd_q.op == OP_WRITE && step_q == WRITE_ACK_STEP) begin
            ack_d = !cmd_q.sack;
          end
          hold_d     = phase_ticks_i - 1'b1;
          was_last_d = ev_last;
          state_d    = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (hold_q == '0) begin
          state_d = was_last_q ? ST_IDLE : ST_EMIT;
        end else begin
          hold_d = hold_q - 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      sub_q       <= SUB_SDA;
      hold_q      <= '0;
      was_last_q  <= 1'b0;
      ack_q       <= 1'b0;
      scl_q       <= '1;
      sda_q       <= '1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      sub_q       <= sub_d;
      hold_q      <= hold_d;
      was_last_q  <= was_last_d;
      ack_q       <= ack_d;
      scl_q       <= scl_d;
      sda_q       <= sda_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    wshift_q <= wshift_d;
    if (emit) begin
      out_scl_q   <= ev_scl;
      out_sda_q   <= ev_sda;
      out_bus_q   <= cmd_q.bus;
      out_ack_q   <= ack_q;
      out_last_q  <= ev_last;
      out_rdata_q <= (cmd_q.op == OP_READ && ev_last) ? cmd_q.sbyte : '0;
    end
  end

  assign evt_o.valid        = out_valid_q;
  assign evt_o.scl_level    = out_scl_q;
  assign evt_o.sda_level    = out_sda_q;
  assign evt_o.bus_out      = out_bus_q;
  assign evt_o.read_data    = out_rdata_q;
  assign evt_o.ack_received = out_ack_q;
  assign evt_o.last         = out_last_q;

  a_emit_then_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (state_q == ST_HOLD && out_valid_q))
    else $error("event emitted without entering hold");

  a_ack_only_in_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(emit && cmd_q.op == OP_WRITE && step_q == WRITE_ACK_STEP) |=> $stable(ack_q))
    else $error("ack flag changed outside the write ack slot");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (step_q <= WRITE_LAST))
    else $error("event index beyond longest command");

  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (state_q == ST_IDLE && q_valid_i))
    else $error("queue popped while a command is active");

endmodule

### hw/rtl/i2c_master_byte_engine_top.sv
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_top
// I2C master byte engine: one command request in, a run of pin events out.
// Timing: from idle, a request passes the queue, the idle pop into the emit
//   state and the event output register before its first event shows. Each
//   event is an emit step plus the hold timer; idle state between commands.
// Throughput: write 27, read 18, start 4, stop 3, ack 3 events per command;
//   hold timer and evt_o.ready set the pace. Requests queue two deep.
// Reset: async active low; all SCL/SDA idle high, ack flag clear, queue
//   empty, phase_ticks back to 125.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  i2cm_cmd_if.sink   cmd_i,
  i2cm_cfg_if.sink   cfg_i,
  i2cm_evt_if.source evt_o
);
  import i2cm_pkg::*;

  logic [TICK_W-1:0] phase_ticks_q, phase_ticks_d;

  cmd_t push_data;
  cmd_t pop_data;
  logic push;
  logic q_full;
  logic q_valid;
  logic q_pop;

  // Config register: always writable, a zero phase_ticks is taken as one.
  assign cfg_i.ready = 1'b1;

  always_comb begin
    phase_ticks_d = phase_ticks_q;
    if (cfg_i.valid) begin
      phase_ticks_d = (cfg_i.phase_ticks == '0) ? TICK_W'(1) : cfg_i.phase_ticks;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= TICK_RESET;
    end else begin
      phase_ticks_q <= phase_ticks_d;
    end
  end

  // Front: accept and classify requests
  i2cm_front u_front (
    .cmd_i       (cmd_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Queue decouples request intake from the slow pin sequencer
  i2cm_cmd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (pop_data),
    .valid_o     (q_valid)
  );

  // Back: walks the event sequence, holds pin state, drives results
  i2cm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .phase_ticks_i (phase_ticks_q),
    .q_valid_i     (q_valid),
    .q_data_i      (pop_data),
    .q_pop_o       (q_pop),
    .evt_o         (evt_o)
  );

endmodule
